// ----- hw/rtl/gamepad_input_qualifier_top_defines.svh -----
// assertion macros shared by the gamepad input qualifier rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef GAMEPAD_INPUT_QUALIFIER_TOP_DEFINES_SVH
`define GAMEPAD_INPUT_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GPIQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GPIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gpiq_pkg.sv -----
// types, constants and the hat decode function of the gamepad input qualifier
// no dependencies
package gpiq_pkg;

    // field widths
    localparam int BUTTON_W = 12;
    localparam int AXIS_W   = 16;
    localparam int HAT_IN_W = 16;
    localparam int THR_W    = 15;
    localparam int MAX_AXES = 4;
    localparam int STICK_W  = 2 * MAX_AXES;
    localparam int HAT_W    = 4;

    // stream and register port widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // parameter defaults
    localparam int NUM_BUTTONS_DEF = 12;
    localparam int NUM_AXES_DEF    = 4;

    // register reset values
    localparam logic [THR_W-1:0] ENGAGE_RESET  = 15'd16384;
    localparam logic [THR_W-1:0] RELEASE_RESET = 15'd24576;

    localparam logic [AXIS_W-1:0] AXIS_TOP = 16'd65535;

    // hat angles in hundredths of a degree
    localparam logic [HAT_IN_W-1:0] HAT_CENTERED = 16'd65535;
    localparam logic [HAT_IN_W-1:0] HAT_FULL     = 16'd36000;
    localparam logic [HAT_IN_W-1:0] HAT_NE       = 16'd4500;
    localparam logic [HAT_IN_W-1:0] HAT_SE       = 16'd13500;
    localparam logic [HAT_IN_W-1:0] HAT_SW       = 16'd22500;
    localparam logic [HAT_IN_W-1:0] HAT_NW       = 16'd31500;

    // hat direction bit positions
    localparam int HAT_UP    = 0;
    localparam int HAT_DOWN  = 1;
    localparam int HAT_LEFT  = 2;
    localparam int HAT_RIGHT = 3;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_ENGAGE  = 1'b0,
        REG_RELEASE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0] engage_thr;
        logic [THR_W-1:0] release_thr;
    } cfg_t;

    // input payload, first field in the lowest bits
    typedef struct packed {
        logic [3:0]          pad;
        logic [AXIS_W-1:0]   axis_ry;
        logic [AXIS_W-1:0]   axis_rx;
        logic [AXIS_W-1:0]   axis_ly;
        logic [AXIS_W-1:0]   axis_lx;
        logic [HAT_IN_W-1:0] hat_angle;
        logic [BUTTON_W-1:0] buttons;
    } in_data_t;

    typedef struct packed {
        logic other_pad_active;
        logic poll_ok;
    } in_user_t;

    // result payload, first field in the lowest bits
    typedef struct packed {
        logic [3:0]          pad;
        logic [HAT_W-1:0]    hat_dirs;
        logic [STICK_W-1:0]  stick_changed;
        logic [STICK_W-1:0]  stick_dirs;
        logic [BUTTON_W-1:0] button_changed;
        logic [BUTTON_W-1:0] button_level;
    } result_t;

    function automatic logic [HAT_W-1:0] hat_decode(input logic [HAT_IN_W-1:0] angle);
        logic [HAT_IN_W-1:0] pov;
        logic [HAT_W-1:0]    dirs;
        begin
            dirs = '0;
            pov  = (angle >= HAT_FULL) ? '0 : angle;
            if (angle != HAT_CENTERED)
            begin
                dirs[HAT_UP]    = (pov < HAT_NE) || (pov > HAT_NW);
                dirs[HAT_DOWN]  = (pov > HAT_SE) && (pov < HAT_SW);
                dirs[HAT_LEFT]  = (pov > HAT_SW) && (pov < HAT_NW);
                dirs[HAT_RIGHT] = (pov > HAT_NE) && (pov < HAT_SE);
            end
            return dirs;
        end
    endfunction

endpackage

// ----- hw/rtl/gamepad_input_qualifier_top.sv -----
// top level of the gamepad input qualifier: stream ports, input and result registers
// depends on gpiq_pkg, gpiq_cfg_regs, gpiq_core and the shared assertion macros
`include "gamepad_input_qualifier_top_defines.svh"

// Gamepad input qualifier. Each input transaction carries one gamepad poll: twelve
// button levels, a hat angle in hundredths of a degree and four 16-bit stick axes.
// A poll is applied when poll_ok is set and other_pad_active is clear; the block
// then updates its held button levels and eight stick direction flags and returns
// one result transaction with levels, change masks and the decoded hat. A skipped
// poll returns the held levels with all masks zero and changes nothing. The first
// applied poll after reset reports every button as changed. Stick flags have
// hysteresis: the low-side flag sets below engage_threshold and clears above
// release_threshold, the high-side flag uses the same distances measured from
// 65535; in between a flag keeps its value. Throughput is one poll per clock
// while m_tready does not stall the result register; an accepted poll is held in
// the input register, moves into the result register when that is free, and
// m_tvalid is set once it lands there. The held state is updated as the poll
// moves into the result register. A stalled result register holds the input
// register, and s_tready drops only when both are full. Write the thresholds
// at byte addresses 0 and 4 only while no poll is in flight.
module gamepad_input_qualifier_top
#(
    parameter int NUM_BUTTONS = gpiq_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_AXES    = gpiq_pkg::NUM_AXES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // poll stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // buttons, hat_angle, axis_lx, axis_ly, axis_rx, axis_ry, zero pad
    input  logic [gpiq_pkg::S_TDATA_W-1:0]    s_tdata,
    // poll_ok, other_pad_active
    input  logic [gpiq_pkg::S_TUSER_W-1:0]    s_tuser,

    // result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // button_level, button_changed, stick_dirs, stick_changed, hat_dirs, zero pad
    output logic [gpiq_pkg::M_TDATA_W-1:0]    m_tdata,
    // applied
    output logic [gpiq_pkg::M_TUSER_W-1:0]    m_tuser,

    // threshold registers
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gpiq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gpiq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gpiq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    gpiq_pkg::cfg_t      cfg;

    // input register stage
    logic                in_valid_reg;
    logic                in_valid_next;
    gpiq_pkg::in_data_t  in_data_reg;
    gpiq_pkg::in_user_t  in_user_reg;

    // result register stage
    logic                out_valid_reg;
    logic                out_valid_next;
    gpiq_pkg::result_t   out_data_reg;
    logic                out_applied_reg;

    gpiq_pkg::result_t   core_result;
    logic                core_applied;

    logic                in_take;   // input transaction this cycle
    logic                advance;   // result register free to load
    logic                commit;    // held poll moves into the result register

    gpiq_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gpiq_core
    #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .NUM_AXES    (NUM_AXES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item_data (in_data_reg),
        .item_user (in_user_reg),
        .cfg       (cfg),
        .applied   (core_applied),
        .result    (core_result)
    );

    // the result register frees up when empty or being taken, and the input
    // register refills in the same cycle it drains, so polls stream one per clock while results are taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign commit   = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= gpiq_pkg::in_data_t'(s_tdata);
            in_user_reg <= gpiq_pkg::in_user_t'(s_tuser);
        end
        if (commit)
        begin
            out_data_reg    <= core_result;
            out_applied_reg <= core_applied;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = gpiq_pkg::M_TDATA_W'(out_data_reg);
    assign m_tuser[0] = out_applied_reg;

    `GPIQ_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, s_tready,
        "input stalled with result register empty")
    `GPIQ_ASSERT_NEXT(a_commit_fills, commit, out_valid_reg,
        "committed poll did not reach the result register")
    `GPIQ_ASSERT_SAME(a_skip_quiet, out_valid_reg && !out_applied_reg,
        (out_data_reg.button_changed == '0) && (out_data_reg.stick_changed == '0)
        && (out_data_reg.hat_dirs == '0), "skipped poll reported a change")

endmodule

// ----- hw/rtl/gpiq_cfg_regs.sv -----
// threshold registers behind the apb-style configuration port
// depends on gpiq_pkg
module gpiq_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gpiq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gpiq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gpiq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output gpiq_pkg::cfg_t                    cfg
);

    gpiq_pkg::cfg_t     cfg_reg;
    gpiq_pkg::cfg_t     cfg_next;
    gpiq_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = gpiq_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                gpiq_pkg::REG_ENGAGE:  cfg_next.engage_thr  = pwdata[gpiq_pkg::THR_W-1:0];
                gpiq_pkg::REG_RELEASE: cfg_next.release_thr = pwdata[gpiq_pkg::THR_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            gpiq_pkg::REG_ENGAGE:
                prdata = gpiq_pkg::APB_DATA_W'(cfg_reg.engage_thr);
            gpiq_pkg::REG_RELEASE:
                prdata = gpiq_pkg::APB_DATA_W'(cfg_reg.release_thr);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.engage_thr  <= gpiq_pkg::ENGAGE_RESET;
            cfg_reg.release_thr <= gpiq_pkg::RELEASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/gpiq_core.sv -----
// held button and stick state with the per-poll qualification logic
// depends on gpiq_pkg and the shared assertion macros
`include "gamepad_input_qualifier_top_defines.svh"

module gpiq_core
#(
    parameter int NUM_BUTTONS = gpiq_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_AXES    = gpiq_pkg::NUM_AXES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  gpiq_pkg::in_data_t   item_data,
    input  gpiq_pkg::in_user_t   item_user,
    input  gpiq_pkg::cfg_t       cfg,
    output logic                 applied,
    output gpiq_pkg::result_t    result
);

    localparam int BW  = gpiq_pkg::BUTTON_W;
    localparam int SW  = gpiq_pkg::STICK_W;
    localparam int AW  = gpiq_pkg::AXIS_W;
    localparam int EFF_BUTTONS = (NUM_BUTTONS < BW) ? NUM_BUTTONS : BW;
    localparam logic [BW-1:0] BTN_MASK = BW'((33'd1 << EFF_BUTTONS) - 33'd1);

    logic [BW-1:0] held_buttons_reg;
    logic [BW-1:0] held_buttons_next;
    logic          seen_reg;
    logic          seen_next;
    logic [SW-1:0] held_stick_reg;
    logic [SW-1:0] held_stick_next;

    logic [BW-1:0] new_buttons;
    logic [SW-1:0] new_stick;
    logic [gpiq_pkg::MAX_AXES-1:0][AW-1:0] axes;
    logic [AW-1:0] eng_lo;
    logic [AW-1:0] rel_lo;
    logic [AW-1:0] eng_hi;
    logic [AW-1:0] rel_hi;

    assign applied     = item_user.poll_ok && !item_user.other_pad_active;
    assign new_buttons = item_data.buttons & BTN_MASK;
    assign axes        = {item_data.axis_ry, item_data.axis_rx,
                          item_data.axis_ly, item_data.axis_lx};

    // thresholds mirrored about full scale for the positive side
    assign eng_lo = AW'(cfg.engage_thr);
    assign rel_lo = AW'(cfg.release_thr);
    assign eng_hi = gpiq_pkg::AXIS_TOP - eng_lo;
    assign rel_hi = gpiq_pkg::AXIS_TOP - rel_lo;

    for (genvar i = 0; i < gpiq_pkg::MAX_AXES; i++)
    begin : g_axis
        if (i < NUM_AXES)
        begin : g_on
            // negative side: bit 2i, positive side: bit 2i+1
            assign new_stick[2*i]   = (axes[i] < eng_lo) ? 1'b1 :
                                      (axes[i] > rel_lo) ? 1'b0 : held_stick_reg[2*i];
            assign new_stick[2*i+1] = (axes[i] > eng_hi) ? 1'b1 :
                                      (axes[i] < rel_hi) ? 1'b0 : held_stick_reg[2*i+1];
        end
        else
        begin : g_off
            assign new_stick[2*i+1:2*i] = 2'b00;
        end
    end

    always_comb
    begin
        held_buttons_next = held_buttons_reg;
        seen_next         = seen_reg;
        held_stick_next   = held_stick_reg;
        if (commit && applied)
        begin
            held_buttons_next = new_buttons;
            seen_next         = 1'b1;
            held_stick_next   = new_stick;
        end
    end

    always_comb
    begin
        result = '0;
        if (applied)
        begin
            result.button_level   = new_buttons;
            result.button_changed = seen_reg ? (new_buttons ^ held_buttons_reg) : BTN_MASK;
            result.stick_dirs     = new_stick;
            result.stick_changed  = new_stick ^ held_stick_reg;
            result.hat_dirs       = gpiq_pkg::hat_decode(item_data.hat_angle);
        end
        else
        begin
            result.button_level   = held_buttons_reg;
            result.stick_dirs     = held_stick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_buttons_reg <= '0;
            seen_reg         <= 1'b0;
            held_stick_reg   <= '0;
        end
        else
        begin
            held_buttons_reg <= held_buttons_next;
            seen_reg         <= seen_next;
            held_stick_reg   <= held_stick_next;
        end
    end

    `GPIQ_ASSERT_NEXT(a_hold_buttons, !(commit && applied), $stable(held_buttons_reg), "buttons moved without an applied poll")
    `GPIQ_ASSERT_NEXT(a_hold_sticks, !(commit && applied), $stable(held_stick_reg), "stick flags moved without an applied poll")
    `GPIQ_ASSERT_NEXT(a_seen_set, commit && applied, seen_reg, "first applied poll did not mark buttons seen")

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for gamepad_input_qualifier_top: poll stream in, result stream out
// depends on gpiq_pkg and the rtl of the block, nothing else
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gpiq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 4;     // two pipeline stages plus margin
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
    localparam int LONG_HOLD      = 64;
    localparam int HOLD_AFTER     = 40;    // results seen before the long hold-off
    localparam int MODE_CYCLES    = 100;   // receiver stall mode lifetime

    // one queued poll, split the way the ports carry it
    typedef struct packed {
        in_user_t user;
        in_data_t data;
    } poll_item_t;

    // one predicted result transaction
    typedef struct packed {
        logic                applied;
        logic [BUTTON_W-1:0] level;
        logic [BUTTON_W-1:0] changed;
        logic [STICK_W-1:0]  dirs;
        logic [STICK_W-1:0]  dirs_changed;
        logic [HAT_W-1:0]    hat;
    } poll_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;  // buttons, hat_angle, axis_lx, ly, rx, ry, zero pad
    logic [S_TUSER_W-1:0]  s_tuser = '0;  // poll_ok, other_pad_active

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;       // level, changed, stick dirs, stick changed, hat
    logic [M_TUSER_W-1:0]  m_tuser;       // applied

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: thresholds as programmed and the held poll state
    logic [THR_W-1:0]      engage_thr = ENGAGE_RESET;
    logic [THR_W-1:0]      release_thr = RELEASE_RESET;
    logic [BUTTON_W-1:0]   held_level = '0;
    logic                  levels_seen = 1'b0;
    logic [STICK_W-1:0]    held_dirs = '0;

    poll_item_t            poll_queue[$];
    poll_outcome_t         pending_results[$];

    int                    polls_queued = 0;
    int                    polls_accepted = 0;
    int                    polls_applied = 0;
    int                    polls_skipped = 0;
    int                    results_seen = 0;
    int                    settings_used = 1;
    int                    errors = 0;

    // sender burst shaping
    int                    burst_left = 0;
    int                    gap_left = 0;

    // receiver stall shaping
    int                    hold_left = 0;
    logic                  long_hold_done = 1'b0;
    int                    stall_mode = 0;
    int                    mode_age = 0;

    int                    idle_cycles = 0;
    logic [BUTTON_W-1:0]   last_buttons = '0;

    gamepad_input_qualifier_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // hysteresis flag: low side measures from 0, high side from full scale
    function automatic logic dir_flag(input logic [AXIS_W-1:0] axis, input logic prev,
                                      input logic high_side);
        if (!high_side)
        begin
            if (axis < engage_thr)
                return 1'b1;
            if (axis > release_thr)
                return 1'b0;
            return prev;
        end
        if (axis > AXIS_TOP - engage_thr)
            return 1'b1;
        if (axis < AXIS_TOP - release_thr)
            return 1'b0;
        return prev;
    endfunction

    // hat angle to up/down/left/right; exact diagonals light nothing
    function automatic logic [HAT_W-1:0] hat_to_dirs(input logic [HAT_IN_W-1:0] angle);
        logic [HAT_IN_W-1:0] a;
        logic [HAT_W-1:0]    d;
        d = '0;
        if (angle == HAT_CENTERED)
            return d;
        // anything past a full turn reads as straight up
        a = (angle >= HAT_FULL) ? '0 : angle;
        d[HAT_UP]    = (a < HAT_NE) || (a > HAT_NW);
        d[HAT_DOWN]  = (a > HAT_SE) && (a < HAT_SW);
        d[HAT_LEFT]  = (a > HAT_SW) && (a < HAT_NW);
        d[HAT_RIGHT] = (a > HAT_NE) && (a < HAT_SE);
        return d;
    endfunction

    // advances the held state by one accepted poll and returns its result
    function automatic poll_outcome_t qualify_poll(input in_user_t u, input in_data_t d);
        poll_outcome_t       o;
        logic [STICK_W-1:0]  next_dirs;
        logic [AXIS_W-1:0]   ax[MAX_AXES];
        o = '0;
        if (u.poll_ok && !u.other_pad_active)
        begin
            o.applied = 1'b1;
            // the first applied poll reports every button
            o.changed = levels_seen ? (d.buttons ^ held_level) : '1;
            held_level  = d.buttons;
            levels_seen = 1'b1;
            ax[0] = d.axis_lx;
            ax[1] = d.axis_ly;
            ax[2] = d.axis_rx;
            ax[3] = d.axis_ry;
            for (int i = 0; i < MAX_AXES; i++)
            begin
                next_dirs[2*i]   = dir_flag(ax[i], held_dirs[2*i], 1'b0);
                next_dirs[2*i+1] = dir_flag(ax[i], held_dirs[2*i+1], 1'b1);
            end
            o.dirs_changed = next_dirs ^ held_dirs;
            held_dirs      = next_dirs;
            o.hat          = hat_to_dirs(d.hat_angle);
            polls_applied++;
        end
        else
        begin
            // skipped poll: held levels only, masks stay zero
            polls_skipped++;
        end
        o.level = held_level;
        o.dirs  = held_dirs;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // driver: poll stream, bursts of random length with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        poll_item_t next_item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            // the transaction on the bus right now is taken at this edge
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(qualify_poll(s_tuser, s_tdata));
                polls_accepted++;
            end
            // a poll still waiting for tready stays put
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (poll_queue.size() > 0)
                begin
                    next_item = poll_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tuser  <= next_item.user;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // new burst; about a third of bursts follow with no gap at all
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: result stream, checks each transaction against the oldest
    // prediction; tready follows a stall mode that changes every so often
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: mismatch in %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        poll_outcome_t want;
        result_t       got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual tuser 0x%0h tdata 0x%0h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("applied", want.applied, m_tuser[0]);
                    check_field("button_level", want.level, got.button_level);
                    check_field("button_changed", want.changed, got.button_changed);
                    check_field("stick_dirs", want.dirs, got.stick_dirs);
                    check_field("stick_changed", want.dirs_changed, got.stick_changed);
                    check_field("hat_dirs", want.hat, got.hat_dirs);
                end
            end

            if (mode_age >= MODE_CYCLES)
            begin
                mode_age   = 0;
                stall_mode = $urandom_range(0, 3);
            end
            else
                mode_age++;

            if (hold_left > 0)
            begin
                // long hold-off in progress; the pipe fills and s_tready drops
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                m_tready      <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_tready <= 1'b1;                              // never stalls
                    1: m_tready <= ($urandom_range(0, 3) != 0);       // light stalls
                    2: m_tready <= ($urandom_range(0, 3) == 0);       // heavy stalls
                    default: m_tready <= mode_age[0];                 // alternates between ready and stalled
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: ends the run when no transaction of any kind happens
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic add_poll(input logic ok, input logic other, input logic [BUTTON_W-1:0] btn,
                            input logic [HAT_IN_W-1:0] hat, input logic [AXIS_W-1:0] lx,
                            input logic [AXIS_W-1:0] ly, input logic [AXIS_W-1:0] rx,
                            input logic [AXIS_W-1:0] ry);
        poll_item_t item;
        item = '0;
        item.user.poll_ok          = ok;
        item.user.other_pad_active = other;
        item.data.buttons          = btn;
        item.data.hat_angle        = hat;
        item.data.axis_lx          = lx;
        item.data.axis_ly          = ly;
        item.data.axis_rx          = rx;
        item.data.axis_ry          = ry;
        poll_queue.push_back(item);
        polls_queued++;
    endtask

    // axis values clustered on the current switching points so the
    // hold band between engage and release gets exercised
    function automatic logic [AXIS_W-1:0] pick_axis();
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = int'(engage_thr) + $urandom_range(0, 4) - 2;
            2, 3: v = int'(release_thr) + $urandom_range(0, 4) - 2;
            4:    v = int'(AXIS_TOP) - int'(engage_thr) + $urandom_range(0, 4) - 2;
            5:    v = int'(AXIS_TOP) - int'(release_thr) + $urandom_range(0, 4) - 2;
            6:    v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : 65535 - $urandom_range(0, 3);
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[AXIS_W-1:0];
    endfunction

    function automatic logic [HAT_IN_W-1:0] pick_hat();
        logic [HAT_IN_W-1:0] diag;
        case ($urandom_range(0, 7))
            0: return HAT_CENTERED;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: diag = HAT_NE;
                    1: diag = HAT_SE;
                    2: diag = HAT_SW;
                    default: diag = HAT_NW;
                endcase
                return diag + $urandom_range(0, 2) - 1;
            end
            2: return $urandom_range(HAT_FULL, 65535);
            default: return $urandom_range(0, HAT_FULL - 1);
        endcase
    endfunction

    task automatic random_polls(input int count);
        logic [BUTTON_W-1:0] btn;
        logic                ok;
        logic                other;
        for (int n = 0; n < count; n++)
        begin
            // buttons: repeat, one toggle, or fresh levels
            case ($urandom_range(0, 3))
                0: btn = last_buttons;
                1: btn = last_buttons ^ (12'd1 << $urandom_range(0, BUTTON_W - 1));
                default: btn = $urandom_range(0, 4095);
            endcase
            last_buttons = btn;
            ok    = ($urandom_range(0, 9) != 0);
            other = ($urandom_range(0, 9) == 0);
            add_poll(ok, other, btn, pick_hat(), pick_axis(), pick_axis(), pick_axis(),
                     pick_axis());
        end
    endtask

    // block idle: every poll taken, every result back, then the pipe latency
    task automatic wait_drained();
        while (polls_accepted != polls_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup then access, followed by a read back of the same register
    task automatic write_threshold(input reg_idx_t idx, input logic [THR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W - THR_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the write lands at this edge
        if (idx == REG_ENGAGE)
            engage_thr = value;
        else
            release_thr = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field(idx == REG_ENGAGE ? "engage_threshold readback" : "release_threshold readback",
                    {{(APB_DATA_W - THR_W){1'b0}}, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] engage, input logic [THR_W-1:0] rel);
        write_threshold(REG_ENGAGE, engage);
        write_threshold(REG_RELEASE, rel);
        settings_used++;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed polls at the reset thresholds: low side on below 16384,
        // off above 24576; high side on above 49151, off below 40959
        // skipped polls before anything was applied
        add_poll(1'b0, 1'b0, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_poll(1'b1, 1'b1, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_poll(1'b0, 1'b1, 12'h000, 16'd9000, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        // first applied poll, all buttons reported even at level zero; hat centered
        add_poll(1'b1, 1'b0, 12'h000, 16'd65535, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        // axis ends set every flag on one side
        add_poll(1'b1, 1'b0, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535);
        // exactly on the engage points: flags hold
        add_poll(1'b1, 1'b0, 12'hFFF, 16'd4500, 16'd16384, 16'd16384, 16'd49151, 16'd49151);
        // on and just past the release points
        add_poll(1'b1, 1'b0, 12'hAAA, 16'd4499, 16'd24576, 16'd24577, 16'd40959, 16'd40958);
        add_poll(1'b1, 1'b0, 12'h555, 16'd4501, 16'd16383, 16'd65535, 16'd49152, 16'd0);
        // skipped poll in the middle reports held levels
        add_poll(1'b1, 1'b1, 12'h000, 16'd18000, 16'd0, 16'd0, 16'd0, 16'd0);
        add_poll(1'b1, 1'b0, 12'h555, 16'd13500, 16'd65535, 16'd0, 16'd32768, 16'd65535);
        add_poll(1'b1, 1'b0, 12'h554, 16'd22500, 16'd24577, 16'd40958, 16'd0, 16'd16383);
        add_poll(1'b1, 1'b0, 12'h154, 16'd31500, 16'd20000, 16'd45000, 16'd20000, 16'd45000);
        add_poll(1'b1, 1'b0, 12'h954, 16'd31501, 16'd65535, 16'd65535, 16'd0, 16'd0);
        add_poll(1'b1, 1'b0, 12'hF0F, 16'd35999, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        // at and beyond a full turn, not centered: reads as up
        add_poll(1'b1, 1'b0, 12'h0F0, 16'd36000, 16'd1, 16'd65534, 16'd12345, 16'd54321);
        add_poll(1'b1, 1'b0, 12'h0F0, 16'd65534, 16'd1, 16'd65534, 16'd12345, 16'd54321);
        add_poll(1'b1, 1'b0, 12'h800, 16'd9000, 16'd24576, 16'd40959, 16'd24576, 16'd40959);
        add_poll(1'b1, 1'b0, 12'h001, 16'd18000, 16'd0, 16'd65535, 16'd0, 16'd65535);
        add_poll(1'b1, 1'b0, 12'h001, 16'd27000, 16'd65535, 16'd0, 16'd65535, 16'd0);
        add_poll(1'b1, 1'b0, 12'h000, 16'd13499, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        add_poll(1'b1, 1'b0, 12'hFFF, 16'd13501, 16'd0, 16'd0, 16'd0, 16'd0);
        add_poll(1'b1, 1'b0, 12'hFFF, 16'd22499, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        add_poll(1'b1, 1'b0, 12'h000, 16'd22501, 16'd32767, 16'd32769, 16'd32767, 16'd32769);
        add_poll(1'b0, 1'b0, 12'hFFF, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
        last_buttons = 12'h000;
        wait_drained();

        // random polls across threshold settings, extremes included;
        // the reversed settings put engage beyond release
        set_thresholds(15'd0, 15'd0);
        random_polls(65);
        wait_drained();
        set_thresholds(15'd32767, 15'd32767);
        random_polls(65);
        wait_drained();
        set_thresholds(15'd8000, 15'd30000);
        random_polls(65);
        wait_drained();
        set_thresholds(15'd30000, 15'd8000);
        random_polls(65);
        wait_drained();
        set_thresholds(15'd1, 15'd32766);
        random_polls(65);
        wait_drained();
        set_thresholds(ENGAGE_RESET, RELEASE_RESET);
        random_polls(65);
        wait_drained();

        $display("run covered %0d polls (%0d applied, %0d skipped) over %0d threshold settings",
                 polls_accepted, polls_applied, polls_skipped, settings_used);
        $display("%0d result transactions checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- gamepad_input_qualifier_top.f -----
+incdir+hw/rtl
hw/rtl/gpiq_pkg.sv
hw/rtl/gpiq_cfg_regs.sv
hw/rtl/gpiq_core.sv
hw/rtl/gamepad_input_qualifier_top.sv
dv/tb_top.sv
